FILE: rtl/core/imd_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the motion detector.
package imd_pkg;

    typedef struct packed {
        logic               func;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_z;
    } imd_in_t;

    typedef struct packed {
        logic        moved;
        logic        origin_valid;
        logic [16:0] accel_dev;
        logic [14:0] orient_dev;
        logic [15:0] gyro_dev;
    } imd_out_t;

    typedef struct packed {
        logic [16:0] away_accel;
        logic [14:0] away_orient;
        logic [15:0] away_gyro;
        logic [16:0] ret_accel;
        logic [14:0] ret_orient;
        logic [15:0] ret_gyro;
    } imd_thr_t;

    localparam logic [2:0] CFG_AWAY_ACCEL  = 3'd0;
    localparam logic [2:0] CFG_AWAY_ORIENT = 3'd1;
    localparam logic [2:0] CFG_AWAY_GYRO   = 3'd2;
    localparam logic [2:0] CFG_RET_ACCEL   = 3'd3;
    localparam logic [2:0] CFG_RET_ORIENT  = 3'd4;
    localparam logic [2:0] CFG_RET_GYRO    = 3'd5;

    localparam int CfgDataW = 17;
    localparam int CordicMaxSteps = 24;
    localparam int ZW = 26;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                5'd0:  v = 26'sd2949120;
                5'd1:  v = 26'sd1740967;
                5'd2:  v = 26'sd919879;
                5'd3:  v = 26'sd466945;
                5'd4:  v = 26'sd234379;
                5'd5:  v = 26'sd117304;
                5'd6:  v = 26'sd58666;
                5'd7:  v = 26'sd29335;
                5'd8:  v = 26'sd14668;
                5'd9:  v = 26'sd7334;
                5'd10: v = 26'sd3667;
                5'd11: v = 26'sd1833;
                5'd12: v = 26'sd917;
                5'd13: v = 26'sd458;
                5'd14: v = 26'sd229;
                5'd15: v = 26'sd115;
                5'd16: v = 26'sd57;
                5'd17: v = 26'sd29;
                5'd18: v = 26'sd14;
                5'd19: v = 26'sd7;
                5'd20: v = 26'sd4;
                5'd21: v = 26'sd2;
                5'd22: v = 26'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/core/imd_front.sv
// Front end: accepts input transactions and the config port, holds thresholds.
module imd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  imd_pkg::imd_in_t in_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [imd_pkg::CfgDataW-1:0] cfg_data,
    output logic            q_valid,
    input  logic            q_ready,
    output imd_pkg::imd_in_t q_data,
    output imd_pkg::imd_thr_t thr
);
    import imd_pkg::*;

    imd_thr_t thr_reg;
    // Two-entry queue toward the back end.
    imd_in_t  buf_reg [2];
    logic     wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign cfg_ready = 1'b1;
    assign thr       = thr_reg;
    assign in_ready  = (cnt_reg != 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_data    = buf_reg[rptr_reg];

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.away_accel  <= 17'd819;
            thr_reg.away_orient <= 15'd320;
            thr_reg.away_gyro   <= 16'd32;
            thr_reg.ret_accel   <= 17'd2048;
            thr_reg.ret_orient  <= 15'd32;
            thr_reg.ret_gyro    <= 16'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_AWAY_ACCEL:  thr_reg.away_accel  <= cfg_data;
                CFG_AWAY_ORIENT: thr_reg.away_orient <= cfg_data[14:0];
                CFG_AWAY_GYRO:   thr_reg.away_gyro   <= cfg_data[15:0];
                CFG_RET_ACCEL:   thr_reg.ret_accel   <= cfg_data;
                CFG_RET_ORIENT:  thr_reg.ret_orient  <= cfg_data[14:0];
                CFG_RET_GYRO:    thr_reg.ret_gyro    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
                wptr_reg <= ~wptr_reg;
            if (q_valid && q_ready)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            buf_reg[wptr_reg] <= in_data;
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) cnt_reg == 2'd2 |-> !in_ready;
    endproperty
    assert property (p_no_overflow) else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad queue count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !q_valid) else $error("empty queue valid");
endmodule

FILE: rtl/core/imd_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module imd_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [35:0] radicand,
    output logic        done,
    output logic [17:0] root
);
    logic [35:0] v_reg, v_next;
    logic [35:0] res_reg, res_next;
    logic [35:0] bit_reg, bit_next;
    logic        busy_reg;
    logic [35:0] trial;

    assign root = res_reg[17:0];
    assign done = busy_reg && (bit_reg == '0);
    assign trial = res_reg + bit_reg;

    // One restoring step per cycle
    always_comb
    begin
        v_next   = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (busy_reg && bit_reg != '0)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
                res_next = res_reg >> 1;
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= 1'b1;
        else if (done)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 36'h4_0000_0000;
        end
        else
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
            bit_reg <= bit_next;
        end
    end
endmodule

FILE: rtl/core/imd_cordic.sv
// Iterative vectoring CORDIC: atan2(y, x) in 1/64 degree, one micro-rotation a cycle.
module imd_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [17:0] y_in,
    input  logic signed [17:0] x_in,
    output logic               done,
    output logic signed [15:0] angle
);
    import imd_pkg::*;

    localparam int XW = 30;

    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]           i_reg;
    logic                 busy_reg, zero_reg;
    logic signed [XW-1:0] xs, ys, x0, y0;
    logic signed [ZW-1:0] z0, zr;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign done = busy_reg && (i_reg == 5'(CORDIC_STEPS));
    assign zr = (z_reg + ZW'(512)) >>> 10;
    assign angle = zero_reg ? '0 : zr[15:0];

    // Quadrant pre-rotation on the scaled operands
    always_comb
    begin
        x0 = XW'(x_in) <<< 8;
        y0 = XW'(y_in) <<< 8;
        z0 = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x0 = XW'(y_in) <<< 8;
                y0 = -(XW'(x_in) <<< 8);
                z0 = ZW'(90 * 65536);
            end
            else
            begin
                x0 = -(XW'(y_in) <<< 8);
                y0 = XW'(x_in) <<< 8;
                z0 = -ZW'(90 * 65536);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= 1'b1;
        else if (done)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
            i_reg    <= '0;
            zero_reg <= (x_in == 0) && (y_in == 0);
        end
        else if (busy_reg && !done)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_lut(i_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_lut(i_reg);
            end
            i_reg <= i_reg + 5'd1;
        end
    end
endmodule

FILE: rtl/core/imd_back.sv
// Back end: sequences the shared root and CORDIC units, keeps origin and away state.
module imd_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  imd_pkg::imd_in_t  q_data,
    input  imd_pkg::imd_thr_t thr,
    output logic              out_valid,
    input  logic              out_ready,
    output imd_pkg::imd_out_t out_data
);
    import imd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RYZ   = 3'd1;
    localparam logic [2:0] S_PITCH = 3'd2;
    localparam logic [2:0] S_ROLL  = 3'd3;
    localparam logic [2:0] S_ADEV  = 3'd4;
    localparam logic [2:0] S_ODEV  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] st_reg;
    logic       go_reg, go_next;
    imd_in_t    item_reg;
    logic signed [15:0] o_ax_reg, o_ay_reg, o_az_reg, o_gz_reg, o_p_reg, o_r_reg;
    logic       oset_reg, away_reg;
    logic signed [15:0] pitch_reg;
    logic [16:0] adev_reg;
    logic [14:0] odev_reg;
    logic [16:0] gdiff;
    logic [15:0] gdev;
    imd_out_t   res_reg;
    logic       ov_reg, ov_next;

    logic        sq_start, sq_done, cd_start, cd_done;
    logic [35:0] sq_rad;
    logic [17:0] sq_root;
    logic signed [17:0] cd_y, cd_x;
    logic signed [15:0] cd_angle;
    logic signed [16:0] dx, dy, dz, dp, dr;
    logic [35:0] sum3;

    assign q_ready   = (st_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = res_reg;

    assign dx = 17'(item_reg.accel_x) - 17'(o_ax_reg);
    assign dy = 17'(item_reg.accel_y) - 17'(o_ay_reg);
    assign dz = 17'(item_reg.accel_z) - 17'(o_az_reg);
    assign dp = 17'(pitch_reg) - 17'(o_p_reg);
    assign dr = 17'(cd_angle) - 17'(o_r_reg);
    assign sum3 = 36'(dx * dx) + 36'(dy * dy) + 36'(dz * dz);
    assign gdiff = 17'(item_reg.gyro_z) - 17'(o_gz_reg);
    assign gdev  = gdiff[16] ? 16'(-gdiff) : gdiff[15:0];

    // Operand selection for the shared units
    always_comb
    begin
        sq_rad = '0;
        cd_y   = 18'(item_reg.accel_y);
        cd_x   = 18'(item_reg.accel_z);
        case (st_reg)
            S_RYZ:   sq_rad = 36'(32'(item_reg.accel_y * item_reg.accel_y))
                            + 36'(32'(item_reg.accel_z * item_reg.accel_z));
            S_PITCH:
            begin
                cd_y = -18'(item_reg.accel_x);
                cd_x = 18'(sq_root);
            end
            S_ADEV:  sq_rad = sum3;
            S_ODEV:  sq_rad = 36'(dp * dp) + 36'(dr * dr);
            default: ;
        endcase
    end

    assign sq_start = go_reg && (st_reg inside {S_RYZ, S_ADEV, S_ODEV});
    assign cd_start = go_reg && (st_reg inside {S_PITCH, S_ROLL});

    imd_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_rad),
        .done(sq_done), .root(sq_root)
    );

    imd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cd_start), .y_in(cd_y), .x_in(cd_x),
        .done(cd_done), .angle(cd_angle)
    );

    // Unit start pulse for the state entered next
    always_comb
    begin
        case (st_reg)
            S_IDLE:  go_next = q_valid;
            S_RYZ:   go_next = sq_done;
            S_PITCH: go_next = cd_done;
            S_ROLL:  go_next = cd_done && !item_reg.func && oset_reg;
            S_ADEV:  go_next = sq_done;
            default: go_next = 1'b0;
        endcase
    end

    // Result valid: load on a finished item, clear once taken
    always_comb
    begin
        ov_next = ov_reg;
        if (st_reg == S_DONE && (!ov_reg || out_ready))
            ov_next = 1'b1;
        else if (ov_reg && out_ready)
            ov_next = 1'b0;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            go_reg   <= 1'b0;
            oset_reg <= 1'b0;
            away_reg <= 1'b0;
            ov_reg   <= 1'b0;
            o_ax_reg <= '0; o_ay_reg <= '0; o_az_reg <= '0;
            o_gz_reg <= '0; o_p_reg  <= '0; o_r_reg  <= '0;
        end
        else
        begin
            go_reg <= go_next;
            ov_reg <= ov_next;
            case (st_reg)
                S_IDLE:
                    if (q_valid)
                        st_reg <= S_RYZ;
                S_RYZ:
                    if (sq_done)
                        st_reg <= S_PITCH;
                S_PITCH:
                    if (cd_done)
                        st_reg <= S_ROLL;
                S_ROLL:
                    if (cd_done)
                    begin
                        if (item_reg.func)
                        begin
                            o_ax_reg <= item_reg.accel_x;
                            o_ay_reg <= item_reg.accel_y;
                            o_az_reg <= item_reg.accel_z;
                            o_gz_reg <= item_reg.gyro_z;
                            o_p_reg  <= pitch_reg;
                            o_r_reg  <= cd_angle;
                            oset_reg <= 1'b1;
                            st_reg   <= S_DONE;
                        end
                        else if (!oset_reg)
                            st_reg <= S_DONE;
                        else
                            st_reg <= S_ADEV;
                    end
                S_ADEV:
                    if (sq_done)
                        st_reg <= S_ODEV;
                S_ODEV:
                    if (sq_done)
                    begin
                        if (!away_reg)
                        begin
                            if (adev_reg > thr.away_accel || ((|sq_root[17:15]) ||
                                sq_root[14:0] > thr.away_orient) || gdev > thr.away_gyro)
                                away_reg <= 1'b1;
                        end
                        else if (adev_reg < thr.ret_accel && !(|sq_root[17:15]) &&
                                 sq_root[14:0] < thr.ret_orient && gdev < thr.ret_gyro)
                            away_reg <= 1'b0;
                        st_reg <= S_DONE;
                    end
                S_DONE:
                    if (!ov_reg || out_ready)
                        st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && q_valid)
        begin
            item_reg <= q_data;
            adev_reg <= '0;
            odev_reg <= '0;
        end
        if (st_reg == S_PITCH && cd_done)
            pitch_reg <= cd_angle;
        if (st_reg == S_ADEV && sq_done)
            adev_reg <= (|sq_root[17]) ? 17'h1FFFF : sq_root[16:0];
        if (st_reg == S_ODEV && sq_done)
            odev_reg <= (|sq_root[17:15]) ? 15'h7FFF : sq_root[14:0];
        if (st_reg == S_DONE && (!ov_reg || out_ready))
        begin
            res_reg.moved        <= oset_reg && away_reg;
            res_reg.origin_valid <= oset_reg;
            res_reg.accel_dev    <= adev_reg;
            res_reg.orient_dev   <= odev_reg;
            res_reg.gyro_dev     <= (oset_reg && !item_reg.func) ? gdev : 16'd0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        !oset_reg |-> !away_reg || $past(oset_reg)) else $error("away without origin");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(sq_start && cd_start)) else $error("both units started");
endmodule

FILE: rtl/core/imu_motion_hysteresis_detector_top.sv
// Top level of the IMU motion hysteresis detector.
// Usage:
//   in channel (in_valid/in_ready/in_data): one sample per transaction; func=1
//   captures the sample as origin, func=0 checks it against the origin.
//   out channel (out_valid/out_ready/out_data): exactly one result per input.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): threshold writes,
//   always ready; write only while the block is idle.
// Processing from input acceptance to out_valid: the queue, then the square roots
//   and CORDIC runs one after another, then the result register. A check with an
//   origin runs three roots and two CORDIC runs; a capture or a check without
//   origin runs one root and two CORDIC runs. The back end takes a new item only
//   once the last one is through: the shared square-root unit and the CORDIC unit
//   are used one after another.
// A two-entry queue lets inputs be taken while the back end works, and the
//   output register lets a finished result wait while new input is queued.
// Reset clears the origin, away flag and queue, and loads default thresholds.
// When the receiver stalls, the result holds and the back end waits to finish.
module imu_motion_hysteresis_detector_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  imd_pkg::imd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output imd_pkg::imd_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [imd_pkg::CfgDataW-1:0] cfg_data
);
    import imd_pkg::*;

    logic     q_valid, q_ready;
    imd_in_t  q_data;
    imd_thr_t thr;

    imd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .q_valid(q_valid),
        .q_ready(q_ready), .q_data(q_data), .thr(thr)
    );

    imd_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .thr(thr), .out_valid(out_valid),
        .out_ready(out_ready), .out_data(out_data)
    );
endmodule

FILE: test/imu_motion_hysteresis_detector_top_test.sv
// Self-checking testbench for the IMU motion hysteresis detector top level.
module imu_motion_hysteresis_detector_top_test;
    import imd_pkg::*;

    localparam int STEPS = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 1350;
    localparam logic FUNC_CHECK = 1'b0;
    localparam logic FUNC_CAPTURE = 1'b1;
    // indexes past the register list, written to show they are ignored
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    // Motion predictor and store of expected results
    class motion_scoreboard;
        imd_thr_t thr;
        logic signed [15:0] org_ax, org_ay, org_az, org_gz, org_pitch, org_roll;
        bit org_set, away;
        imd_out_t expected_results[$];
        int mismatches;
        int checked;
        longint atan_steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0};

        function void clear();
            thr.away_accel = 17'd819;
            thr.away_orient = 15'd320;
            thr.away_gyro = 16'd32;
            thr.ret_accel = 17'd2048;
            thr.ret_orient = 15'd32;
            thr.ret_gyro = 16'd8;
            {org_ax, org_ay, org_az, org_gz, org_pitch, org_roll} = '0;
            org_set = 0;
            away = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_threshold(logic [2:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                CFG_AWAY_ACCEL:  thr.away_accel = val[16:0];
                CFG_AWAY_ORIENT: thr.away_orient = val[14:0];
                CFG_AWAY_GYRO:   thr.away_gyro = val[15:0];
                CFG_RET_ACCEL:   thr.ret_accel = val[16:0];
                CFG_RET_ORIENT:  thr.ret_orient = val[14:0];
                CFG_RET_GYRO:    thr.ret_gyro = val[15:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned res, bit_w;
            res = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v) bit_w >>= 2;
            while (bit_w != 0) begin
                if (v >= res + bit_w) begin
                    v -= res + bit_w;
                    res = (res >> 1) + bit_w;
                end else
                    res >>= 1;
                bit_w >>= 2;
            end
            return res;
        endfunction

        // angle of (x, y) in 1/64 degree
        function longint arctan2(longint yi, longint xi);
            longint x, y, z, t;
            if (xi == 0 && yi == 0) return 0;
            x = xi * 256;
            y = yi * 256;
            z = 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = 90 * 65536;
                end else begin
                    x = -y; y = t; z = -90 * 65536;
                end
            end
            for (int i = 0; i < STEPS; i++) begin
                t = x;
                if (y > 0) begin
                    x = x + (y >>> i);
                    y = y - (t >>> i);
                    z += atan_steps[i];
                end else begin
                    x = x - (y >>> i);
                    y = y + (t >>> i);
                    z -= atan_steps[i];
                end
            end
            return (z + 512) >>> 10;
        endfunction

        // note an accepted input transaction and queue its result
        function void note_input(imd_in_t s);
            longint ax, ay, az, gz, pitch, roll, dx, dy, dz, dp, dr, dg;
            longint unsigned adev, odev, gdev;
            imd_out_t r;
            ax = s.accel_x; ay = s.accel_y; az = s.accel_z; gz = s.gyro_z;
            pitch = arctan2(-ax, longint'(int_root(ay * ay + az * az)));
            roll = arctan2(ay, az);
            adev = 0; odev = 0; gdev = 0;
            if (s.func == FUNC_CAPTURE) begin
                org_ax = s.accel_x; org_ay = s.accel_y; org_az = s.accel_z;
                org_gz = s.gyro_z;
                org_pitch = pitch[15:0]; org_roll = roll[15:0];
                org_set = 1;
            end else if (org_set) begin
                dx = ax - org_ax; dy = ay - org_ay; dz = az - org_az;
                dp = pitch - org_pitch; dr = roll - org_roll; dg = gz - org_gz;
                adev = int_root(dx * dx + dy * dy + dz * dz);
                if (adev > 131071) adev = 131071;
                odev = int_root(dp * dp + dr * dr);
                if (odev > 32767) odev = 32767;
                gdev = dg < 0 ? -dg : dg;
                if (gdev > 65535) gdev = 65535;
                if (!away) begin
                    if (adev > thr.away_accel || odev > thr.away_orient ||
                        gdev > thr.away_gyro)
                        away = 1;
                end else if (adev < thr.ret_accel && odev < thr.ret_orient &&
                             gdev < thr.ret_gyro)
                    away = 0;
            end
            r.moved = org_set && away;
            r.origin_valid = org_set;
            r.accel_dev = adev[16:0];
            r.orient_dev = odev[14:0];
            r.gyro_dev = gdev[15:0];
            expected_results.push_back(r);
        endfunction

        function void check_result(imd_out_t got);
            imd_out_t exp_r;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            exp_r = expected_results.pop_front();
            checked++;
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d: expected %p, got %p",
                             checked, exp_r, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    imd_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    imd_out_t out_data;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    motion_scoreboard sb;
    bit idling_on = 1;
    bit busy = 1;
    int stall_cycles = 0;
    int items_sent = 0;
    int captures_sent = 0;

    imu_motion_hysteresis_detector_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // Result side: check at the rising edge, pick the stall at the falling edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) sb.check_result(out_data);
            @(negedge clk);
            out_ready = idling_on ? ($urandom_range(99) >= 16) : 1'b1;
        end
    end

    // Watchdog: cycles without any transaction while work is open
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !busy)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding",
                     sb.expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(imd_in_t s);
        @(negedge clk);
        while (idling_on && $urandom_range(99) < 16)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        in_data = s;
        do @(posedge clk); while (!in_ready);
        sb.note_input(s);
        items_sent++;
        if (s.func == FUNC_CAPTURE) captures_sent++;
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CfgDataW-1:0] val);
        @(negedge clk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_threshold(idx, val);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic wait_idle();
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic imd_in_t sample(logic f, int ax, int ay, int az, int gz);
        imd_in_t s;
        s.func = f;
        s.accel_x = ax[15:0];
        s.accel_y = ay[15:0];
        s.accel_z = az[15:0];
        s.gyro_z = gz[15:0];
        return s;
    endfunction

    function automatic int clip16(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    // origin plus a perturbation of random scale, so the flag swings both ways
    function automatic imd_in_t near_sample(imd_in_t o);
        int span;
        case ($urandom_range(3))
            0: span = 4;
            1: span = 64;
            2: span = 1024;
            default: span = 8192;
        endcase
        return sample(FUNC_CHECK,
            clip16(int'(o.accel_x) + $urandom_range(2 * span) - span),
            clip16(int'(o.accel_y) + $urandom_range(2 * span) - span),
            clip16(int'(o.accel_z) + $urandom_range(2 * span) - span),
            clip16(int'(o.gyro_z) + $urandom_range(2 * span) - span));
    endfunction

    task automatic random_phase(int count);
        imd_in_t org, s;
        org = sample(FUNC_CAPTURE, $urandom, $urandom, $urandom, $urandom);
        send_item(org);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(19))
                0, 1:
                begin
                    org = sample(FUNC_CAPTURE, $urandom, $urandom, $urandom, $urandom);
                    s = org;
                end
                2, 3: s = sample(1'($urandom), $urandom, $urandom, $urandom, $urandom);
                default: s = near_sample(org);
            endcase
            send_item(s);
        end
    endtask

    task automatic load_thresholds(logic [16:0] aa, logic [14:0] ao, logic [15:0] ag,
                                   logic [16:0] ra, logic [14:0] ro, logic [15:0] rg);
        write_reg(CFG_AWAY_ACCEL, aa);
        write_reg(CFG_AWAY_ORIENT, CfgDataW'(ao));
        write_reg(CFG_AWAY_GYRO, CfgDataW'(ag));
        write_reg(CFG_RET_ACCEL, ra);
        write_reg(CFG_RET_ORIENT, CfgDataW'(ro));
        write_reg(CFG_RET_GYRO, CfgDataW'(rg));
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed part with reset thresholds
        send_item(sample(FUNC_CHECK, 100, -200, 4096, 5));          // no origin yet
        send_item(sample(FUNC_CAPTURE, 0, 0, 0, 0));                // both angle inputs zero
        send_item(sample(FUNC_CHECK, 0, 0, 0, 0));
        send_item(sample(FUNC_CAPTURE, 0, 0, 4096, 0));
        send_item(sample(FUNC_CHECK, 0, 0, 4096, 32));              // equal to away level
        send_item(sample(FUNC_CHECK, 0, 0, 4096, 33));              // goes away
        send_item(sample(FUNC_CAPTURE, 0, 0, 4096, 0));             // flag kept on capture
        send_item(sample(FUNC_CHECK, 0, 0, 4096, 8));               // equal to return level
        send_item(sample(FUNC_CHECK, 0, 0, 4096, 7));               // returns
        send_item(sample(FUNC_CHECK, 0, 4096, 0, 0));               // orientation swing
        send_item(sample(FUNC_CHECK, 0, 0, 4100, 0));
        send_item(sample(FUNC_CAPTURE, -32768, -32768, -32768, -32768));
        send_item(sample(FUNC_CHECK, 32767, 32767, 32767, 32767));
        send_item(sample(FUNC_CHECK, -32768, 32767, -32768, 32767));
        send_item(sample(FUNC_CAPTURE, 32767, 0, -1, 32767));
        send_item(sample(FUNC_CHECK, -32768, -1, 0, -32768));
        send_item(sample(FUNC_CHECK, -4096, 0, -4096, 0));
        send_item(sample(FUNC_CAPTURE, 1, -1, 1, -1));
        send_item(sample(FUNC_CHECK, 0, 1, -1, 1));
        wait_idle();

        // Random phases over several threshold settings
        random_phase(250);
        wait_idle();
        load_thresholds('0, '0, '0, '0, '0, '0);
        write_reg(CFG_SPARE_A, CfgDataW'($urandom));
        random_phase(150);
        wait_idle();
        load_thresholds('1, '1, '1, '1, '1, '1);
        write_reg(CFG_SPARE_B, CfgDataW'($urandom));
        random_phase(150);
        wait_idle();
        load_thresholds(17'd400, 15'd200, 16'd64, 17'd100, 15'd60, 16'd16);
        idling_on = 0;
        random_phase(300);
        wait_idle();
        idling_on = 1;
        load_thresholds(17'($urandom), 15'($urandom), 16'($urandom),
                        17'($urandom), 15'($urandom), 16'($urandom));
        random_phase(150);
        wait_idle();
        load_thresholds(17'($urandom_range(4000)), 15'($urandom_range(600)),
                        16'($urandom_range(200)), 17'($urandom_range(4000)),
                        15'($urandom_range(600)), 16'($urandom_range(200)));
        random_phase(RANDOM_ITEMS - 1000);
        wait_idle();
        busy = 0;

        $display("%0d samples sent (%0d captures), %0d results checked, six threshold sets",
                 items_sent, captures_sent, sb.checked);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.expected_results.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/imd_pkg.sv
rtl/core/imd_front.sv
rtl/core/imd_sqrt.sv
rtl/core/imd_cordic.sv
rtl/core/imd_back.sv
rtl/core/imu_motion_hysteresis_detector_top.sv
test/imu_motion_hysteresis_detector_top_test.sv
